FILE: sv/rnm_pkg.sv
// Shared types and constants for the RTP/NTP timestamp mapper.
package rnm_pkg;

  // Number of cells in the arithmetic chain: one quotient bit per cell.
  localparam int unsigned NUM_CELLS = 64;
  // Leading cells that also carry one multiplier bit of the NTP to RTP path.
  localparam int unsigned MUL_CELLS = 32;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_MAPPING_VALID = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_RTP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_SEC    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_FRAC   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CLOCK_RATE    = 3'd4;

  // Reset value of the media clock rate.
  localparam logic [31:0] RATE_RESET = 32'd90000;

  // Operation codes.
  localparam logic OP_RTP_TO_NTP = 1'b0;
  localparam logic OP_NTP_TO_RTP = 1'b1;

  // Work carried from cell to cell.
  // mdr: dividend bits (RTP to NTP) or fraction multiplier bits (NTP to RTP).
  // whl: whole-seconds multiplier bits (NTP to RTP only).
  // rem: division remainder, or low word of whole seconds times rate.
  // acc: quotient, or fraction times rate.
  typedef struct packed {
    logic        op;
    logic [31:0] mdr;
    logic [31:0] whl;
    logic [31:0] rem;
    logic [63:0] acc;
  } cell_data_t;

  // Anchor and gating settings seen by the output stage.
  typedef struct packed {
    logic        mapping_valid;
    logic [31:0] anchor_rtp;
    logic [31:0] anchor_sec;
    logic [31:0] anchor_frac;
  } anchor_t;

endpackage

FILE: sv/rnm_front.sv
// Input stage: forms the tick difference or the NTP delta from the anchor.
module rnm_front import rnm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_vld,
  input  logic        op,
  input  logic [31:0] rtp_timestamp,
  input  logic [31:0] ntp_seconds,
  input  logic [31:0] ntp_fraction,
  input  anchor_t     anchor,
  output logic        vld_r,
  output cell_data_t  data_r
);

  cell_data_t  data_nxt;
  logic [63:0] delta;

  // Modular differences from the anchor.
  always_comb begin
    delta = {ntp_seconds, ntp_fraction} - {anchor.anchor_sec, anchor.anchor_frac};
    data_nxt.op  = op;
    data_nxt.rem = '0;
    data_nxt.acc = '0;
    if (op == OP_RTP_TO_NTP) begin
      data_nxt.mdr = rtp_timestamp - anchor.anchor_rtp;
      data_nxt.whl = '0;
    end else begin
      data_nxt.mdr = delta[31:0];
      data_nxt.whl = delta[63:32];
    end
  end

  // Valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  // Payload register.
  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

endmodule

FILE: sv/rnm_cell.sv
// One cell of the chain: a restoring-division step or a shift-add multiply step.
module rnm_cell import rnm_pkg::*; #(
  parameter int unsigned INDEX = 0
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic [31:0] rate,
  input  logic        vld_in,
  input  cell_data_t  data_in,
  output logic        vld_r,
  output cell_data_t  data_r
);

  localparam bit DO_MUL = (INDEX < MUL_CELLS);

  cell_data_t  data_nxt;
  logic [32:0] trial;
  logic [32:0] diff;

  always_comb begin
    data_nxt = data_in;
    trial    = {data_in.rem, data_in.mdr[31]};
    diff     = trial - {1'b0, rate};
    if (data_in.op == OP_RTP_TO_NTP) begin
      // Shift in the next dividend bit and subtract the rate when it fits.
      data_nxt.mdr = {data_in.mdr[30:0], 1'b0};
      if (trial >= {1'b0, rate}) begin
        data_nxt.rem = diff[31:0];
        data_nxt.acc = {data_in.acc[62:0], 1'b1};
      end else begin
        data_nxt.rem = trial[31:0];
        data_nxt.acc = {data_in.acc[62:0], 1'b0};
      end
    end else if (DO_MUL) begin
      // Multiply MSB first: double the partial products, add rate per set bit.
      data_nxt.mdr = {data_in.mdr[30:0], 1'b0};
      data_nxt.whl = {data_in.whl[30:0], 1'b0};
      data_nxt.acc = {data_in.acc[62:0], 1'b0}
                   + (data_in.mdr[31] ? {32'd0, rate} : 64'd0);
      data_nxt.rem = {data_in.rem[30:0], 1'b0}
                   + (data_in.whl[31] ? rate : 32'd0);
    end
  end

  // Valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  // Payload register.
  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

endmodule

FILE: sv/rnm_back.sv
// Output stage: adds the anchor and holds the result item until it is taken.
module rnm_back import rnm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        vld_in,
  input  cell_data_t  data_in,
  input  anchor_t     anchor,
  output logic        out_vld_r,
  output logic [31:0] ntp_sec_r,
  output logic [31:0] ntp_frac_r,
  output logic [31:0] rtp_ts_r
);

  logic [63:0] ntp_sum;
  logic [31:0] rtp_sum;
  logic [31:0] ntp_sec_nxt;
  logic [31:0] ntp_frac_nxt;
  logic [31:0] rtp_ts_nxt;

  // Final sums; unused fields and an unset anchor give zero.
  always_comb begin
    ntp_sum      = {anchor.anchor_sec, anchor.anchor_frac} + data_in.acc;
    rtp_sum      = data_in.rem + data_in.acc[63:32] + anchor.anchor_rtp;
    ntp_sec_nxt  = '0;
    ntp_frac_nxt = '0;
    rtp_ts_nxt   = '0;
    if (anchor.mapping_valid) begin
      if (data_in.op == OP_RTP_TO_NTP) begin
        ntp_sec_nxt  = ntp_sum[63:32];
        ntp_frac_nxt = ntp_sum[31:0];
      end else begin
        rtp_ts_nxt = rtp_sum;
      end
    end
  end

  // Valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= vld_in;
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (en) begin
      ntp_sec_r  <= ntp_sec_nxt;
      ntp_frac_r <= ntp_frac_nxt;
      rtp_ts_r   <= rtp_ts_nxt;
    end
  end

endmodule

FILE: sv/rtp_ntp_timestamp_mapper.sv
// Top level of the RTP/NTP timestamp mapper: configuration, cell chain, output.
//
// Converts an RTP timestamp to a 32.32 NTP time (opcode 0) or an NTP time to an
// RTP timestamp (opcode 1) against a sender-report anchor and a media clock rate.
// The block accepts one item every clock cycle unless the output stalls; each item
// passes one input stage, a chain of 64 cells that each produce one quotient bit
// of the 64-bit division (the first 32 cells also do one bit of the two shift-add
// multiplications), and one output register. A stalled output holds the whole
// chain. The user must see that configuration is written only while no item is
// in flight, not enforced by the block. A rate of zero gives an all-ones quotient.
module rtp_ntp_timestamp_mapper import rnm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // Configuration write port.
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_wdata,
  // Input channel.
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_opcode,
  input  logic [31:0]          in_rtp_timestamp,
  input  logic [31:0]          in_ntp_seconds,
  input  logic [31:0]          in_ntp_fraction,
  // Result channel.
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [31:0]          out_ntp_seconds,
  output logic [31:0]          out_ntp_fraction,
  output logic [31:0]          out_rtp_timestamp
);

  logic        mapping_valid_r;
  logic [31:0] anchor_rtp_r;
  logic [31:0] anchor_sec_r;
  logic [31:0] anchor_frac_r;
  logic [31:0] clock_rate_r;
  anchor_t     anchor;
  logic        en;

  logic        vld_chain  [0:NUM_CELLS];
  cell_data_t  data_chain [0:NUM_CELLS];

  // Configuration registers; writes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mapping_valid_r <= 1'b0;
      anchor_rtp_r    <= '0;
      anchor_sec_r    <= '0;
      anchor_frac_r   <= '0;
      clock_rate_r    <= RATE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAPPING_VALID: mapping_valid_r <= cfg_wdata[0];
        REG_ANCHOR_RTP:    anchor_rtp_r    <= cfg_wdata;
        REG_ANCHOR_SEC:    anchor_sec_r    <= cfg_wdata;
        REG_ANCHOR_FRAC:   anchor_frac_r   <= cfg_wdata;
        REG_CLOCK_RATE:    clock_rate_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign anchor.mapping_valid = mapping_valid_r;
  assign anchor.anchor_rtp    = anchor_rtp_r;
  assign anchor.anchor_sec    = anchor_sec_r;
  assign anchor.anchor_frac   = anchor_frac_r;

  // The whole pipeline moves unless a finished item waits at the output.
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Input stage.
  rnm_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en),
    .in_vld        (in_valid),
    .op            (in_opcode),
    .rtp_timestamp (in_rtp_timestamp),
    .ntp_seconds   (in_ntp_seconds),
    .ntp_fraction  (in_ntp_fraction),
    .anchor        (anchor),
    .vld_r         (vld_chain[0]),
    .data_r        (data_chain[0])
  );

  // Chain of arithmetic cells.
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    rnm_cell #(
      .INDEX (i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .rate    (clock_rate_r),
      .vld_in  (vld_chain[i]),
      .data_in (data_chain[i]),
      .vld_r   (vld_chain[i+1]),
      .data_r  (data_chain[i+1])
    );
  end

  // Output stage.
  rnm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .vld_in     (vld_chain[NUM_CELLS]),
    .data_in    (data_chain[NUM_CELLS]),
    .anchor     (anchor),
    .out_vld_r  (out_valid),
    .ntp_sec_r  (out_ntp_seconds),
    .ntp_frac_r (out_ntp_fraction),
    .rtp_ts_r   (out_rtp_timestamp)
  );

endmodule
